// ===== rtl/core/cfv_pkg.sv =====
package cfv_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic [2:0] kind;
    } cfv_char_t;

    typedef struct packed {
        logic       accepted;
        logic [2:0] error_code;
    } cfv_res_t;

    typedef logic [2:0] cfv_err_t;

    localparam cfv_err_t ERR_NONE     = 3'd0;
    localparam cfv_err_t ERR_CHAR     = 3'd1;
    localparam cfv_err_t ERR_SYNTAX   = 3'd2;
    localparam cfv_err_t ERR_RANGE    = 3'd3;
    localparam cfv_err_t ERR_REVERSED = 3'd4;
    localparam cfv_err_t ERR_STEP     = 3'd5;

    localparam logic [2:0] KIND_MINUTE  = 3'd0;
    localparam logic [2:0] KIND_HOUR    = 3'd1;
    localparam logic [2:0] KIND_DAY     = 3'd2;
    localparam logic [2:0] KIND_MONTH   = 3'd3;
    localparam logic [2:0] KIND_WEEKDAY = 3'd4;

    localparam logic [6:0] ACC_MAX = 7'd127;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // legal value window per field kind; kinds without meaning accept nothing
    function automatic logic value_ok(input logic [6:0] v, input logic [2:0] kind);
        logic ok;
        ok = 1'b0;
        case (kind)
            KIND_MINUTE:  ok = (v <= 7'd59);
            KIND_HOUR:    ok = (v <= 7'd23);
            KIND_DAY:     ok = (v >= 7'd1) && (v <= 7'd31);
            KIND_MONTH:   ok = (v >= 7'd1) && (v <= 7'd12);
            KIND_WEEKDAY: ok = (v <= 7'd6);
            default:      ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ===== rtl/core/cfv_parser.sv =====
module cfv_parser
    import cfv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  cfv_char_t beat,
    output logic      res_push,
    output cfv_res_t  res_beat
);

    typedef enum logic [2:0] {
        PH_TERM       = 3'd0,
        PH_STAR       = 3'd1,
        PH_LOW        = 3'd2,
        PH_HIGH       = 3'd3,
        PH_STAR_STEP  = 3'd4,
        PH_RANGE_STEP = 3'd5
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [6:0] low_reg, low_next;
    logic [6:0] high_reg, high_next;
    logic [6:0] acc_reg, acc_next;
    logic       seen_reg, seen_next;
    cfv_err_t   err_reg, err_next;

    logic       is_digit;
    logic       is_end;
    logic       char_ok;
    logic       in_number;
    logic [3:0] digit;
    logic [7:0] digit_full;
    logic [10:0] acc_sum;
    logic [7:0] span;

    assign is_digit   = (beat.ch >= CH_ZERO) && (beat.ch <= CH_NINE);
    assign is_end     = (beat.ch == CH_NUL);
    assign char_ok    = is_end || (beat.ch == CH_STAR) || (beat.ch == CH_DASH)
                        || (beat.ch == CH_SLASH) || (beat.ch == CH_COMMA);
    assign in_number  = (phase_reg == PH_LOW) || (phase_reg == PH_HIGH)
                        || (phase_reg == PH_STAR_STEP) || (phase_reg == PH_RANGE_STEP);
    assign digit_full = beat.ch - CH_ZERO;
    assign digit      = digit_full[3:0];
    assign acc_sum    = ({4'd0, acc_reg} * 11'd10) + {7'd0, digit};
    // range width high - low + 1, only used once low <= high is known
    assign span       = {1'b0, high_reg} - {1'b0, low_reg} + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;

        if (err_reg == ERR_NONE)
        begin
            if (is_digit)
            begin
                if (phase_reg == PH_TERM)
                begin
                    phase_next = PH_LOW;
                    acc_next   = {3'd0, digit};
                    seen_next  = 1'b1;
                end
                else if (in_number)
                begin
                    acc_next  = (acc_sum > {4'd0, ACC_MAX}) ? ACC_MAX : acc_sum[6:0];
                    seen_next = 1'b1;
                end
                else
                begin
                    err_next = ERR_SYNTAX;
                end
            end
            else
            begin
                // number just ended: range check first
                if (in_number && seen_reg)
                begin
                    if (!value_ok(acc_reg, beat.kind))
                    begin
                        err_next = ERR_RANGE;
                    end
                    else if (phase_reg == PH_LOW)
                    begin
                        low_next = acc_reg;
                    end
                    else if (phase_reg == PH_HIGH)
                    begin
                        high_next = acc_reg;
                        if (low_reg > acc_reg)
                        begin
                            err_next = ERR_REVERSED;
                        end
                    end
                    else if (phase_reg == PH_RANGE_STEP)
                    begin
                        if ({1'b0, acc_reg} > span)
                        begin
                            err_next = ERR_STEP;
                        end
                    end
                end

                if (!char_ok && (err_next == ERR_NONE))
                begin
                    err_next = ERR_CHAR;
                end

                if (err_next == ERR_NONE)
                begin
                    unique case (phase_reg)
                        PH_TERM:
                        begin
                            if (beat.ch == CH_STAR)
                                phase_next = PH_STAR;
                            else
                                err_next = ERR_SYNTAX;
                        end
                        PH_STAR:
                        begin
                            if (beat.ch == CH_SLASH)
                            begin
                                phase_next = PH_STAR_STEP;
                                acc_next   = 7'd0;
                                seen_next  = 1'b0;
                            end
                            else if (beat.ch == CH_COMMA)
                                phase_next = PH_TERM;
                            else if (!is_end)
                                err_next = ERR_SYNTAX;
                        end
                        PH_LOW:
                        begin
                            if (beat.ch == CH_DASH)
                            begin
                                phase_next = PH_HIGH;
                                acc_next   = 7'd0;
                                seen_next  = 1'b0;
                            end
                            else if (beat.ch == CH_COMMA)
                                phase_next = PH_TERM;
                            else if (!is_end)
                                err_next = ERR_SYNTAX;
                        end
                        PH_HIGH:
                        begin
                            if (!seen_reg)
                                err_next = ERR_SYNTAX;
                            else if (beat.ch == CH_SLASH)
                            begin
                                phase_next = PH_RANGE_STEP;
                                acc_next   = 7'd0;
                                seen_next  = 1'b0;
                            end
                            else if (beat.ch == CH_COMMA)
                                phase_next = PH_TERM;
                            else if (!is_end)
                                err_next = ERR_SYNTAX;
                        end
                        default:
                        begin
                            if (!seen_reg)
                                err_next = ERR_SYNTAX;
                            else if (beat.ch == CH_COMMA)
                                phase_next = PH_TERM;
                            else if (!is_end)
                                err_next = ERR_SYNTAX;
                        end
                    endcase
                end
            end
        end

        res_push            = fire && is_end;
        res_beat.accepted   = (err_next == ERR_NONE);
        res_beat.error_code = err_next;

        // end of field: back to the idle parse state
        if (is_end)
        begin
            phase_next = PH_TERM;
            low_next   = 7'd0;
            high_next  = 7'd0;
            acc_next   = 7'd0;
            seen_next  = 1'b0;
            err_next   = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TERM;
            low_reg   <= 7'd0;
            high_reg  <= 7'd0;
            acc_reg   <= 7'd0;
            seen_reg  <= 1'b0;
            err_reg   <= ERR_NONE;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== rtl/core/cfv_out_buf.sv =====
module cfv_out_buf
    import cfv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  cfv_res_t push_beat,
    output logic     full,
    output logic     res_valid,
    input  logic     res_stall,
    output cfv_res_t res
);

    logic     out_valid_reg;
    cfv_res_t out_data_reg;
    logic     skid_valid_reg;
    cfv_res_t skid_data_reg;
    logic     pop;

    assign pop       = out_valid_reg && !res_stall;
    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;
    assign full      = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (!out_valid_reg || pop)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_data_reg <= push_beat;
            else
                skid_data_reg <= push_beat;
        end
    end

endmodule

// ===== rtl/core/cron_field_validator.sv =====
// channel | direction | handshake              | beat
// char    | in        | char_valid, char_stall | char_data : ch[7:0], kind[2:0]
// res     | out       | res_valid, res_stall   | res_data  : accepted, error_code[2:0]
//
// one character per cycle while char_stall is low; the parser state is a single register stage
// a verdict is registered when its NUL beat is taken and leaves from the result register
// a second result stage absorbs one verdict while res is stalled; char_stall
// rises only when both stages hold a verdict
// rst_n clears the parser to the start of a field and empties both stages
module cron_field_validator
    import cfv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_stall,
    input  cfv_char_t char_data,
    output logic      res_valid,
    input  logic      res_stall,
    output cfv_res_t  res_data
);

    logic     fire;
    logic     push;
    cfv_res_t push_beat;
    logic     full;

    assign char_stall = full;
    assign fire       = char_valid && !full;

    cfv_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .beat     (char_data),
        .res_push (push),
        .res_beat (push_beat)
    );

    cfv_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_beat (push_beat),
        .full      (full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res_data)
    );

endmodule
